@@ design/vrbs_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vrbs_pkg
// Shared types and constants of the variable-length record stack: request
// codes, the controller command and the datapath status word.
// ----------------------------------------------------------------------------
package vrbs_pkg;

	localparam int BYTE_W = 8;
	localparam int LANES  = 8;
	localparam int LANE_W = $clog2(LANES);
	localparam int DATA_W = BYTE_W * LANES;
	localparam int LEN_W  = 4;
	localparam int REQ_W  = 2;

	typedef enum logic [REQ_W-1:0] {
		REQ_PUSH  = 2'd0,
		REQ_POP   = 2'd1,
		REQ_PEEK  = 2'd2,
		REQ_CLEAR = 2'd3
	} req_t;

	// Command from the controller to the datapath, one per cycle.
	typedef enum logic [2:0] {
		OP_NONE,
		OP_LOAD,
		OP_WR_DATA,
		OP_WR_TRL,
		OP_RD_TRL,
		OP_CALC,
		OP_RD_DATA,
		OP_FINISH
	} op_t;

	typedef struct packed {
		logic is_push;
		logic is_read;
		logic push_go;
		logic read_go;
		logic trl_ok;
		logic len_zero;
		logic n_zero;
		logic wr_last;
		logic trl_last;
		logic rdd_last;
		logic out_free;
		logic empty;
	} status_t;

endpackage

@@ design/vrbs_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vrbs_ctrl
// Sequencer of the record stack. Steps the datapath through the byte writes
// of a push or the trailer and data reads of a pop or peek.
// ----------------------------------------------------------------------------
module vrbs_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  vrbs_pkg::status_t status,
	output vrbs_pkg::op_t     cmd
);
	import vrbs_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DECIDE,
		S_PUSH_DATA,
		S_PUSH_TRL,
		S_RD_TRL,
		S_TRL_WAIT,
		S_RD_CALC,
		S_RD_DATA,
		S_RD_WAIT,
		S_FINISH
	} state_t;

	state_t state_q;

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		unique case (state_q)
			S_IDLE:      cmd = in_valid ? OP_LOAD : OP_NONE;
			S_PUSH_DATA: cmd = OP_WR_DATA;
			S_PUSH_TRL:  cmd = OP_WR_TRL;
			S_RD_TRL:    cmd = OP_RD_TRL;
			S_RD_CALC:   cmd = OP_CALC;
			S_RD_DATA:   cmd = OP_RD_DATA;
			S_FINISH:    cmd = status.out_free ? OP_FINISH : OP_NONE;
			default:     cmd = OP_NONE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) state_q <= S_DECIDE;
				end
				S_DECIDE: begin
					if (status.is_push && status.push_go) begin
						state_q <= status.len_zero ? S_PUSH_TRL : S_PUSH_DATA;
					end else if (status.is_read && status.read_go && status.trl_ok) begin
						state_q <= S_RD_TRL;
					end else begin
						state_q <= S_FINISH;
					end
				end
				S_PUSH_DATA: begin
					if (status.wr_last) state_q <= S_PUSH_TRL;
				end
				S_PUSH_TRL: begin
					if (status.trl_last) state_q <= S_FINISH;
				end
				S_RD_TRL: begin
					if (status.trl_last) state_q <= S_TRL_WAIT;
				end
				S_TRL_WAIT: state_q <= S_RD_CALC;
				S_RD_CALC:  state_q <= S_RD_DATA;
				S_RD_DATA: begin
					if (status.n_zero || status.rdd_last) state_q <= S_RD_WAIT;
				end
				S_RD_WAIT: state_q <= S_FINISH;
				S_FINISH: begin
					if (status.out_free) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

@@ design/vrbs_dp.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vrbs_dp
// Datapath of the record stack: byte store, fill level, byte pointers,
// trailer decode and the result register.
// ----------------------------------------------------------------------------
module vrbs_dp #(
	parameter int STACK_BYTES    = 1024,
	parameter int MAX_ELEM_BYTES = 8,
	parameter int TRAILER_BYTES  = 8
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  vrbs_pkg::op_t                 cmd,
	output vrbs_pkg::status_t             status,
	input  logic [vrbs_pkg::REQ_W-1:0]    req_type,
	input  logic [vrbs_pkg::DATA_W-1:0]   elem_data,
	input  logic [vrbs_pkg::LEN_W-1:0]    elem_len,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic                          ok,
	output logic [vrbs_pkg::DATA_W-1:0]   out_data,
	output logic [vrbs_pkg::LEN_W-1:0]    out_len,
	output logic                          is_empty,
	output logic                          would_overflow
);
	import vrbs_pkg::*;

	localparam int AW = $clog2(STACK_BYTES);
	localparam int TW = $clog2(STACK_BYTES + 1);
	localparam logic [TW-1:0]     TOP_MAX  = TW'(STACK_BYTES);
	localparam logic [TW-1:0]     TRL      = TW'(TRAILER_BYTES);
	localparam logic [LEN_W-1:0]  MAXL     = LEN_W'(MAX_ELEM_BYTES);
	localparam logic [BYTE_W-1:0] MAXB     = BYTE_W'(MAX_ELEM_BYTES);
	localparam logic [LEN_W-1:0]  TRL_LAST = LEN_W'(TRAILER_BYTES - 1);

	logic [BYTE_W-1:0] mem [STACK_BYTES];
	logic [BYTE_W-1:0] mem_rd_q;

	req_t              req_q;
	logic [DATA_W-1:0] data_q;
	logic [LEN_W-1:0]  len_q;
	logic [TW-1:0]     top_q;
	logic [TW-1:0]     wp_q;
	logic [TW-1:0]     rp_q;
	logic [LEN_W-1:0]  cnt_q;
	logic [BYTE_W-1:0] byte0_q;
	logic              hi_nz_q;
	logic [LEN_W-1:0]  n_q;
	logic [TW-1:0]     base_q;
	logic [DATA_W-1:0] odata_q;
	logic              rd_vld_s1;
	logic              rd_trl_s1;
	logic [LANE_W-1:0] rd_lane_s1;

	logic              out_valid_q;
	logic              ok_q;
	logic [DATA_W-1:0] out_data_q;
	logic [LEN_W-1:0]  out_len_q;
	logic              is_empty_q;
	logic              over_q;

	logic              push_go;
	logic              read_go;
	logic              we;
	logic              re;
	logic [BYTE_W-1:0] wdata;
	logic [TW-1:0]     tpos;
	logic [LEN_W-1:0]  v_cl;
	logic [LEN_W-1:0]  stored;
	logic [LEN_W-1:0]  n_new;
	logic [TW-1:0]     base_new;
	logic [TW-1:0]     new_top;
	logic              ok_new;

	// A record of len bytes plus its trailer fits below the stack end.
	function automatic logic fits_f(input logic [LEN_W-1:0] len, input logic [TW-1:0] top);
		fits_f = (TW'(len) + TRL) <= (TOP_MAX - top);
	endfunction

	assign push_go = (len_q <= MAXL) && fits_f(len_q, top_q);
	assign read_go = (top_q != '0);

	assign status.is_push  = (req_q == REQ_PUSH);
	assign status.is_read  = (req_q == REQ_POP) || (req_q == REQ_PEEK);
	assign status.push_go  = push_go;
	assign status.read_go  = read_go;
	assign status.trl_ok   = (top_q >= TRL);
	assign status.len_zero = (len_q == '0);
	assign status.n_zero   = (n_q == '0);
	assign status.wr_last  = (cnt_q == len_q - LEN_W'(1));
	assign status.trl_last = (cnt_q == TRL_LAST);
	assign status.rdd_last = (cnt_q == n_q - LEN_W'(1));
	assign status.out_free = !out_valid_q || out_ready;
	assign status.empty    = (top_q == '0);

	// Trailer decode: the stored length is clamped to the element limit and
	// to the bytes that lie below the trailer.
	assign tpos     = top_q - TRL;
	assign v_cl     = (hi_nz_q || (byte0_q > MAXB)) ? MAXL : byte0_q[LEN_W-1:0];
	assign stored   = (TW'(v_cl) > tpos) ? tpos[LEN_W-1:0] : v_cl;
	assign n_new    = (len_q < stored) ? len_q : stored;
	assign base_new = tpos - TW'(stored);

	always_comb begin
		case (req_q) inside
			REQ_PUSH: begin
				ok_new  = push_go;
				new_top = push_go ? wp_q : top_q;
			end
			REQ_POP: begin
				ok_new  = read_go;
				new_top = read_go ? base_q : top_q;
			end
			REQ_PEEK: begin
				ok_new  = read_go;
				new_top = top_q;
			end
			default: begin
				ok_new  = 1'b1;
				new_top = '0;
			end
		endcase
	end

	assign we    = (cmd == OP_WR_DATA) || (cmd == OP_WR_TRL);
	assign re    = (cmd == OP_RD_TRL) || ((cmd == OP_RD_DATA) && (n_q != '0));
	// Trailer byte 0 holds the length; the higher trailer bytes are zero.
	assign wdata = (cmd == OP_WR_DATA) ? data_q[BYTE_W*cnt_q[LANE_W-1:0] +: BYTE_W] :
	               (cnt_q == '0)       ? BYTE_W'(len_q) : '0;

	always_ff @(posedge clk) begin
		if (we) mem[wp_q[AW-1:0]] <= wdata;
		if (re) mem_rd_q <= mem[rp_q[AW-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			top_q       <= '0;
			cnt_q       <= '0;
			rd_vld_s1   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			rd_vld_s1 <= re;
			if (cmd == OP_FINISH) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (cmd) inside
				OP_LOAD, OP_CALC: cnt_q <= '0;
				OP_WR_DATA:       cnt_q <= status.wr_last ? '0 : cnt_q + LEN_W'(1);
				OP_WR_TRL, OP_RD_TRL, OP_RD_DATA: cnt_q <= cnt_q + LEN_W'(1);
				OP_FINISH:        top_q <= new_top;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd == OP_LOAD) begin
			req_q   <= req_t'(req_type);
			data_q  <= elem_data;
			len_q   <= elem_len;
			wp_q    <= top_q;
			rp_q    <= top_q - TRL;
			byte0_q <= '0;
			hi_nz_q <= 1'b0;
			n_q     <= '0;
			base_q  <= '0;
			odata_q <= '0;
		end
		if (we) wp_q <= wp_q + TW'(1);
		if (re) begin
			rp_q       <= rp_q + TW'(1);
			rd_lane_s1 <= cnt_q[LANE_W-1:0];
			rd_trl_s1  <= (cmd == OP_RD_TRL);
		end
		if (cmd == OP_CALC) begin
			n_q    <= n_new;
			base_q <= base_new;
			rp_q   <= base_new;
		end
		// Read data is registered and arrives in the cycle after its address was issued.
		if (rd_vld_s1) begin
			if (rd_trl_s1) begin
				if (rd_lane_s1 == '0) byte0_q <= mem_rd_q;
				else hi_nz_q <= hi_nz_q | (|mem_rd_q);
			end else begin
				odata_q[BYTE_W*rd_lane_s1 +: BYTE_W] <= mem_rd_q;
			end
		end
		if (cmd == OP_FINISH) begin
			ok_q       <= ok_new;
			out_data_q <= odata_q;
			out_len_q  <= n_q;
			is_empty_q <= (new_top == '0);
			over_q     <= !fits_f(len_q, new_top);
		end
	end

	assign out_valid      = out_valid_q;
	assign ok             = ok_q;
	assign out_data       = out_data_q;
	assign out_len        = out_len_q;
	assign is_empty       = is_empty_q;
	assign would_overflow = over_q;

endmodule

@@ design/variable_record_byte_stack_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// variable_record_byte_stack_core
// Stack of variable-length records in a byte-wide store. Each record is its
// data bytes followed by a little-endian length trailer.
//
//   channel  handshake            payload
//   in       in_valid/in_ready    req_type, elem_data, elem_len
//   out      out_valid/out_ready  ok, out_data, out_len, is_empty,
//                                 would_overflow
//
// One word is taken at a time. A push writes its data bytes and then its
// trailer; a pop or peek reads the trailer and then its data bytes; a clear
// or a refused request goes straight to loading the result. The byte-wide
// store moves one byte per cycle. A result waiting in the output register
// does not stop the next word from being taken; only loading the following
// result waits for it. Reset empties the stack at once; the store contents
// are not cleared.
// ----------------------------------------------------------------------------
module variable_record_byte_stack_core #(
	parameter int STACK_BYTES    = 1024,
	parameter int MAX_ELEM_BYTES = 8,
	parameter int TRAILER_BYTES  = 8
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [vrbs_pkg::REQ_W-1:0]  req_type,
	input  logic [vrbs_pkg::DATA_W-1:0] elem_data,
	input  logic [vrbs_pkg::LEN_W-1:0]  elem_len,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic                        ok,
	output logic [vrbs_pkg::DATA_W-1:0] out_data,
	output logic [vrbs_pkg::LEN_W-1:0]  out_len,
	output logic                        is_empty,
	output logic                        would_overflow
);
	import vrbs_pkg::*;

	op_t     cmd;
	status_t status;

	vrbs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.status   (status),
		.cmd      (cmd)
	);

	vrbs_dp #(
		.STACK_BYTES    (STACK_BYTES),
		.MAX_ELEM_BYTES (MAX_ELEM_BYTES),
		.TRAILER_BYTES  (TRAILER_BYTES)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.status         (status),
		.req_type       (req_type),
		.elem_data      (elem_data),
		.elem_len       (elem_len),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.ok             (ok),
		.out_data       (out_data),
		.out_len        (out_len),
		.is_empty       (is_empty),
		.would_overflow (would_overflow)
	);

	// Only one word is in work at a time.
	a_one_word: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("new word taken while one is in work");

	// A result is loaded only when the output register can take it.
	a_finish_free: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd == OP_FINISH) |-> status.out_free)
		else $error("result loaded over a pending one");

	// The reported empty flag tracks the fill level it was taken from.
	a_empty_track: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (is_empty == status.empty))
		else $error("empty flag disagrees with the fill level");

	// A refused request returns no bytes.
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !ok) |-> ((out_len == '0) && (out_data == '0)))
		else $error("refused request returned data");

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for variable_record_byte_stack_core. A shadow copy of
// the record stack predicts every reply. Directed tests cover the empty,
// full and refused cases. A random phase follows with fill, drain, mixed
// and noise traffic. Both handshakes idle at random.
// ----------------------------------------------------------------------------
module tb;
	import vrbs_pkg::*;

	localparam int STACK_BYTES = 1024;
	localparam int REC_MAX     = 8;
	localparam int TRAILER     = 8;

	typedef struct packed {
		logic              ok;
		logic [DATA_W-1:0] data;
		logic [LEN_W-1:0]  len;
		logic              empty;
		logic              ovf;
	} stack_reply_t;

	typedef enum int {PH_FILL, PH_DRAIN, PH_MIXED, PH_NOISE} phase_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              in_valid = 1'b0;
	logic              in_ready;
	logic [REQ_W-1:0]  req_type = '0;
	logic [DATA_W-1:0] elem_data = '0;
	logic [LEN_W-1:0]  elem_len = '0;
	logic              out_valid;
	logic              out_ready = 1'b0;
	logic              ok;
	logic [DATA_W-1:0] out_data;
	logic [LEN_W-1:0]  out_len;
	logic              is_empty;
	logic              would_overflow;

	// Shadow of the stack contents and fill level.
	logic [7:0]   shadow_bytes [STACK_BYTES];
	int           shadow_fill = 0;
	stack_reply_t expected_replies [$];
	int           fault_count = 0;
	logic         no_idle = 1'b0;

	variable_record_byte_stack_core #(
		.STACK_BYTES   (STACK_BYTES),
		.MAX_ELEM_BYTES(REC_MAX),
		.TRAILER_BYTES (TRAILER)
	) dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.req_type      (req_type),
		.elem_data     (elem_data),
		.elem_len      (elem_len),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.ok            (ok),
		.out_data      (out_data),
		.out_len       (out_len),
		.is_empty      (is_empty),
		.would_overflow(would_overflow)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic logic [DATA_W-1:0] rand64();
		return {$urandom, $urandom};
	endfunction

	function automatic stack_reply_t apply_stack_op(input req_t req,
			input logic [DATA_W-1:0] data, input logic [LEN_W-1:0] len);
		stack_reply_t r;
		logic [63:0]  trl;
		int           i, tpos, stored, base, n;
		r = '0;
		case (req)
		REQ_PUSH: begin
			if (int'(len) <= REC_MAX && int'(len) + TRAILER <= STACK_BYTES - shadow_fill) begin
				for (i = 0; i < int'(len); i++)
					shadow_bytes[shadow_fill + i] = data[8*i +: 8];
				shadow_fill += int'(len);
				trl = 64'(len);
				for (i = 0; i < TRAILER; i++)
					shadow_bytes[shadow_fill + i] = trl[8*i +: 8];
				shadow_fill += TRAILER;
				r.ok = 1'b1;
			end
		end
		REQ_POP, REQ_PEEK: begin
			if (shadow_fill != 0) begin
				stored = 0;
				base   = 0;
				if (shadow_fill >= TRAILER) begin
					tpos = shadow_fill - TRAILER;
					trl  = '0;
					for (i = 0; i < TRAILER; i++)
						trl[8*i +: 8] = shadow_bytes[tpos + i];
					// A damaged trailer is clamped to the element limit and to what can lie below it.
					if (trl > 64'(REC_MAX))
						trl = 64'(REC_MAX);
					if (trl > 64'(tpos))
						trl = 64'(tpos);
					stored = int'(trl);
					base   = tpos - stored;
				end
				n = (int'(len) < stored) ? int'(len) : stored;
				for (i = 0; i < n; i++)
					r.data[8*i +: 8] = shadow_bytes[base + i];
				r.len = 4'(n);
				r.ok  = 1'b1;
				if (req == REQ_POP)
					shadow_fill = base;
			end
		end
		default: begin
			shadow_fill = 0;
			r.ok = 1'b1;
		end
		endcase
		r.empty = (shadow_fill == 0);
		r.ovf   = (int'(len) + TRAILER > STACK_BYTES - shadow_fill);
		return r;
	endfunction

	// Presents one word, holds it until taken, and records the predicted reply.
	task automatic issue_request(input req_t req, input logic [DATA_W-1:0] data,
			input logic [LEN_W-1:0] len);
		int gap;
		gap = no_idle ? 0 : $urandom_range(0, 11);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid  <= 1'b1;
		req_type  <= req;
		elem_data <= data;
		elem_len  <= len;
		do @(posedge clk); while (in_ready !== 1'b1);
		expected_replies.push_back(apply_stack_op(req, data, len));
	endtask

	task automatic check_field(input string name, input logic [63:0] want,
			input logic [63:0] got);
		if (got !== want) begin
			fault_count++;
			$error("%s: expected %h, actual %h", name, want, got);
		end
	endtask

	always @(posedge clk) begin
		stack_reply_t want;
		if (arst_n === 1'b1 && out_valid === 1'b1 && out_ready === 1'b1) begin
			if (expected_replies.size() == 0) begin
				fault_count++;
				$error("result word with no request pending");
			end else begin
				want = expected_replies.pop_front();
				check_field("ok", 64'(want.ok), 64'(ok));
				check_field("out_data", want.data, out_data);
				check_field("out_len", 64'(want.len), 64'(out_len));
				check_field("is_empty", 64'(want.empty), 64'(is_empty));
				check_field("would_overflow", 64'(want.ovf), 64'(would_overflow));
			end
		end
	end

	// Result side: stalls at random before each word.
	initial begin : result_sink
		int stall;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			stall = no_idle ? 0 : $urandom_range(0, 11);
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (out_valid !== 1'b1);
		end
	end

	task automatic test_empty_stack();
		issue_request(REQ_POP, '1, 4'd8);
		issue_request(REQ_PEEK, '1, 4'd8);
		issue_request(REQ_CLEAR, '0, 4'd0);
		// A zero-length record is only its trailer.
		issue_request(REQ_PUSH, '1, 4'd0);
		issue_request(REQ_PEEK, '0, 4'd8);
		issue_request(REQ_POP, '0, 4'd0);
	endtask

	task automatic test_record_bytes();
		issue_request(REQ_PUSH, '1, 4'd8);
		issue_request(REQ_PUSH, 64'h0123_4567_89ab_cda5, 4'd1);
		issue_request(REQ_PUSH, '1, 4'd9);
		issue_request(REQ_PUSH, '1, 4'd15);
		issue_request(REQ_PEEK, '0, 4'd15);
		issue_request(REQ_POP, '0, 4'd0);
		issue_request(REQ_PEEK, '0, 4'd3);
		issue_request(REQ_POP, '0, 4'd8);
		issue_request(REQ_PUSH, 64'h5555_5555_5555_5555, 4'd8);
		issue_request(REQ_POP, '0, 4'd15);
		// Bytes above the record length must not leak into the reply.
		issue_request(REQ_PUSH, 64'haaaa_aaaa_aaaa_aaaa, 4'd4);
		issue_request(REQ_PEEK, '0, 4'd8);
		issue_request(REQ_CLEAR, '1, 4'd15);
		issue_request(REQ_POP, '0, 4'd8);
	endtask

	task automatic test_full_stack();
		issue_request(REQ_CLEAR, '0, 4'd8);
		while (shadow_fill + REC_MAX + TRAILER <= STACK_BYTES)
			issue_request(REQ_PUSH, rand64(), 4'd8);
		issue_request(REQ_PUSH, rand64(), 4'd0);
		issue_request(REQ_PEEK, '0, 4'd8);
		issue_request(REQ_POP, '0, 4'd8);
		issue_request(REQ_PUSH, rand64(), 4'd8);
		issue_request(REQ_PUSH, rand64(), 4'd1);
		issue_request(REQ_CLEAR, '0, 4'd0);
	endtask

	task automatic test_random_traffic(input int n_items);
		phase_t           phase;
		int               left, r, i;
		req_t             req;
		logic [LEN_W-1:0] len;
		phase = PH_MIXED;
		left  = 0;
		for (i = 0; i < n_items; i++) begin
			if (left == 0) begin
				phase   = phase_t'($urandom_range(0, 3));
				left    = (phase == PH_FILL) ? $urandom_range(60, 150) : $urandom_range(20, 80);
				no_idle = ($urandom_range(0, 3) == 0);
			end
			left--;
			r = $urandom_range(0, 99);
			case (phase)
			PH_FILL:  req = (r < 85) ? REQ_PUSH : (r < 93) ? REQ_PEEK : (r < 99) ? REQ_POP : REQ_CLEAR;
			PH_DRAIN: req = (r < 70) ? REQ_POP : (r < 85) ? REQ_PEEK : (r < 99) ? REQ_PUSH : REQ_CLEAR;
			PH_MIXED: req = (r < 40) ? REQ_PUSH : (r < 70) ? REQ_POP : (r < 98) ? REQ_PEEK : REQ_CLEAR;
			default:  req = req_t'($urandom_range(0, 3));
			endcase
			// Pushes are mostly legal lengths; oversized ones are refused.
			if (req == REQ_PUSH && phase != PH_NOISE && $urandom_range(0, 11) != 0)
				len = 4'($urandom_range(0, REC_MAX));
			else
				len = 4'($urandom_range(0, 15));
			issue_request(req, rand64(), len);
		end
		no_idle = 1'b0;
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		test_empty_stack();
		test_record_bytes();
		test_full_stack();
		test_random_traffic(860);
		in_valid <= 1'b0;
		while (expected_replies.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
		if (fault_count == 0)
			$display("tb: PASS");
		else
			$display("tb: FAIL");
		$finish;
	end

	initial begin
		#2_000_000;
		$display("tb: FAIL");
		$finish;
	end

endmodule

@@ filelist.f @@
design/vrbs_pkg.sv
design/vrbs_ctrl.sv
design/vrbs_dp.sv
design/variable_record_byte_stack_core.sv
tb/tb.sv
